>>> design/gdod_pkg.sv
package gdod_pkg;

  // Calendar range and field widths
  localparam int unsigned MAX_YEAR = 9999;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MON_W    = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned OFF_W    = 22;
  localparam int unsigned DIFF_W   = 23;
  localparam int unsigned ST_W     = 2;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SUB  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DIFF = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD   = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  // Month numbers used by the walkers
  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  // Day number of the last representable date, 0001-01-01 being day 0
  localparam int unsigned PRIOR_YEARS = MAX_YEAR - 1;
  localparam bit          MAX_LEAP    = ((MAX_YEAR % 4 == 0) && (MAX_YEAR % 100 != 0)) ||
                                        (MAX_YEAR % 400 == 0);
  localparam int unsigned LAST_DAY    = PRIOR_YEARS * 365 + PRIOR_YEARS / 4 -
                                        PRIOR_YEARS / 100 + PRIOR_YEARS / 400 +
                                        (MAX_LEAP ? 365 : 364);
  localparam int unsigned DN_W        = $clog2(LAST_DAY + 1);

  // Compare width for offset arithmetic and signed difference width
  localparam int unsigned CMP_W = ((DN_W > OFF_W) ? DN_W : OFF_W) + 1;
  localparam int unsigned SD_W  = (((DN_W + 1) > DIFF_W) ? (DN_W + 1) : DIFF_W) + 1;

  localparam int DIFF_MAX_I = (2 ** (DIFF_W - 1)) - 1;
  localparam int DIFF_MIN_I = -(2 ** (DIFF_W - 1));
  localparam logic signed [SD_W-1:0] DIFF_MAX_S = SD_W'(DIFF_MAX_I);
  localparam logic signed [SD_W-1:0] DIFF_MIN_S = SD_W'(DIFF_MIN_I);

  // Length of a month, zero for a month number that does not exist
  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MON_FEB:                                    len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Year and month inside the supported range (day is checked later)
  function automatic logic ym_ok(input logic [YEAR_W-1:0] y, input logic [MON_W-1:0] m);
    return (y != '0) && (32'(y) <= MAX_YEAR) && (m >= MON_JAN) && (m <= MON_DEC);
  endfunction

endpackage

>>> design/gregorian_date_offset_and_difference_core.sv
// Gregorian date arithmetic core.
// Input channel (in_valid_i / in_stall_o) carries a command, a primary date,
// a day offset and a second date. Add and subtract shift the primary date by
// the offset; difference gives primary minus second date in days.
// Output channel (out_valid_o / out_stall_i) returns one transaction per input:
// shifted date, signed difference and a status (ok, invalid input, range).
// Every date is converted to a day number by walking years from year 1 and
// then months, one year or month per cycle through a single accumulator;
// add and subtract then walk the result back into year, month and day.
// One transaction is worked on at a time; in_stall_o is high from acceptance
// until the result is moved into the output register.
// A finished result waits in the output register while out_stall_i is high,
// and the next input transaction may already be accepted meanwhile.
// Reset clears the sequencer and the output valid flag; no stored state
// survives between transactions.
module gregorian_date_offset_and_difference_core
  import gdod_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [CMD_W-1:0]         command_i,
  input  logic [YEAR_W-1:0]        year_i,
  input  logic [MON_W-1:0]         month_i,
  input  logic [DAY_W-1:0]         day_i,
  input  logic [OFF_W-1:0]         offset_days_i,
  input  logic [YEAR_W-1:0]        other_year_i,
  input  logic [MON_W-1:0]         other_month_i,
  input  logic [DAY_W-1:0]         other_day_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [YEAR_W-1:0]        result_year_o,
  output logic [MON_W-1:0]         result_month_o,
  output logic [DAY_W-1:0]         result_day_o,
  output logic signed [DIFF_W-1:0] day_difference_o,
  output logic [ST_W-1:0]          status_o
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DNY  = 3'd1;  // day number: walk years
  localparam logic [2:0] S_DNM  = 3'd2;  // day number: walk months
  localparam logic [2:0] S_ADJ  = 3'd3;  // apply offset or subtract
  localparam logic [2:0] S_RY   = 3'd4;  // back to date: walk years
  localparam logic [2:0] S_RM   = 3'd5;  // back to date: walk months
  localparam logic [2:0] S_FIN  = 3'd6;  // hand result to output register

  logic [2:0]               state_q, state_d;
  logic                     second_q, second_d;
  logic                     out_valid_q, out_valid_d;

  logic [CMD_W-1:0]         cmd_q, cmd_d;
  logic [YEAR_W-1:0]        y_q, y_d, oy_q, oy_d;
  logic [MON_W-1:0]         m_q, m_d, om_q, om_d;
  logic [DAY_W-1:0]         d_q, d_d, od_q, od_d;
  logic [OFF_W-1:0]         off_q, off_d;

  logic [DN_W-1:0]          acc_q, acc_d;
  logic [DN_W-1:0]          n1_q, n1_d;
  logic [YEAR_W-1:0]        yc_q, yc_d;
  logic [MON_W-1:0]         mc_q, mc_d;
  logic [1:0]               mod4_q, mod4_d;
  logic [6:0]               mod100_q, mod100_d;
  logic [8:0]               mod400_q, mod400_d;

  logic [YEAR_W-1:0]        ry_q, ry_d;
  logic [MON_W-1:0]         rm_q, rm_d;
  logic [DAY_W-1:0]         rd_q, rd_d;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic [ST_W-1:0]          st_q, st_d;

  logic [YEAR_W-1:0]        ores_y_q, ores_y_d;
  logic [MON_W-1:0]         ores_m_q, ores_m_d;
  logic [DAY_W-1:0]         ores_d_q, ores_d_d;
  logic signed [DIFF_W-1:0] odiff_q, odiff_d;
  logic [ST_W-1:0]          ost_q, ost_d;

  // Walk helpers
  logic [YEAR_W-1:0]        tgt_y;
  logic [MON_W-1:0]         tgt_m;
  logic [DAY_W-1:0]         tgt_d;
  logic                     leap_c;
  logic [DN_W-1:0]          ylen_c;
  logic [DN_W-1:0]          mlen_c;
  logic [DAY_W-1:0]         tgt_mlen;
  logic [CMP_W-1:0]         room_c;
  logic signed [SD_W-1:0]   sd_c;
  logic                     in_acc;
  logic                     out_free;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign tgt_y    = second_q ? oy_q : y_q;
  assign tgt_m    = second_q ? om_q : m_q;
  assign tgt_d    = second_q ? od_q : d_q;
  assign leap_c   = (mod4_q == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));
  assign ylen_c   = DN_W'(365) + DN_W'(leap_c);
  assign mlen_c   = DN_W'(month_len(mc_q, leap_c));
  assign tgt_mlen = month_len(tgt_m, leap_c);
  assign room_c   = CMP_W'(LAST_DAY) - CMP_W'(acc_q);
  assign sd_c     = $signed(SD_W'(n1_q)) - $signed(SD_W'(acc_q));

  // Sequencer and shared accumulator
  always_comb begin
    state_d     = state_q;
    second_d    = second_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_d       = cmd_q;
    y_d         = y_q;
    m_d         = m_q;
    d_d         = d_q;
    off_d       = off_q;
    oy_d        = oy_q;
    om_d        = om_q;
    od_d        = od_q;
    acc_d       = acc_q;
    n1_d        = n1_q;
    yc_d        = yc_q;
    mc_d        = mc_q;
    mod4_d      = mod4_q;
    mod100_d    = mod100_q;
    mod400_d    = mod400_q;
    ry_d        = ry_q;
    rm_d        = rm_q;
    rd_d        = rd_q;
    diff_d      = diff_q;
    st_d        = st_q;
    ores_y_d    = ores_y_q;
    ores_m_d    = ores_m_q;
    ores_d_d    = ores_d_q;
    odiff_d     = odiff_q;
    ost_d       = ost_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d    = command_i;
          y_d      = year_i;
          m_d      = month_i;
          d_d      = day_i;
          off_d    = offset_days_i;
          oy_d     = other_year_i;
          om_d     = other_month_i;
          od_d     = other_day_i;
          second_d = 1'b0;
          acc_d    = '0;
          yc_d     = YEAR_W'(1);
          mod4_d   = 2'd1;
          mod100_d = 7'd1;
          mod400_d = 9'd1;
          ry_d     = '0;
          rm_d     = '0;
          rd_d     = '0;
          diff_d   = '0;
          st_d     = ST_OK;
          // reject unused command and out-of-range year or month up front
          if ((command_i != CMD_ADD && command_i != CMD_SUB && command_i != CMD_DIFF) ||
              !ym_ok(year_i, month_i) ||
              (command_i == CMD_DIFF && !ym_ok(other_year_i, other_month_i))) begin
            st_d    = ST_BAD;
            state_d = S_FIN;
          end else begin
            state_d = S_DNY;
          end
        end
      end

      S_DNY: begin
        // add one year length per cycle until the target year is reached
        if (yc_q == tgt_y) begin
          mc_d    = MON_JAN;
          state_d = S_DNM;
        end else begin
          acc_d    = acc_q + ylen_c;
          yc_d     = yc_q + YEAR_W'(1);
          mod4_d   = mod4_q + 2'd1;
          mod100_d = (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
          mod400_d = (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
        end
      end

      S_DNM: begin
        if (mc_q == tgt_m) begin
          // leap flag is now that of the target year: check the day
          if (tgt_d == '0 || tgt_d > tgt_mlen) begin
            st_d    = ST_BAD;
            state_d = S_FIN;
          end else if (cmd_q == CMD_DIFF && !second_q) begin
            n1_d     = acc_q + DN_W'(tgt_d) - DN_W'(1);
            second_d = 1'b1;
            acc_d    = '0;
            yc_d     = YEAR_W'(1);
            mod4_d   = 2'd1;
            mod100_d = 7'd1;
            mod400_d = 9'd1;
            state_d  = S_DNY;
          end else begin
            acc_d   = acc_q + DN_W'(tgt_d) - DN_W'(1);
            state_d = S_ADJ;
          end
        end else begin
          acc_d = acc_q + mlen_c;
          mc_d  = mc_q + MON_W'(1);
        end
      end

      S_ADJ: begin
        yc_d     = YEAR_W'(1);
        mod4_d   = 2'd1;
        mod100_d = 7'd1;
        mod400_d = 9'd1;
        state_d  = S_RY;
        case (cmd_q)
          CMD_DIFF: begin
            state_d = S_FIN;
            if (sd_c > DIFF_MAX_S) begin
              diff_d = DIFF_MAX_S[DIFF_W-1:0];
              st_d   = ST_RANGE;
            end else if (sd_c < DIFF_MIN_S) begin
              diff_d = DIFF_MIN_S[DIFF_W-1:0];
              st_d   = ST_RANGE;
            end else begin
              diff_d = sd_c[DIFF_W-1:0];
            end
          end
          CMD_ADD: begin
            // saturate at the last representable day
            if (CMP_W'(off_q) > room_c) begin
              acc_d = DN_W'(LAST_DAY);
              st_d  = ST_RANGE;
            end else begin
              acc_d = DN_W'(CMP_W'(acc_q) + CMP_W'(off_q));
            end
          end
          CMD_SUB: begin
            // saturate at the first day
            if (CMP_W'(off_q) > CMP_W'(acc_q)) begin
              acc_d = '0;
              st_d  = ST_RANGE;
            end else begin
              acc_d = DN_W'(CMP_W'(acc_q) - CMP_W'(off_q));
            end
          end
          default: begin
            st_d    = ST_BAD;
            state_d = S_FIN;
          end
        endcase
      end

      S_RY: begin
        // peel off whole years while the remainder covers one
        if (acc_q >= ylen_c) begin
          acc_d    = acc_q - ylen_c;
          yc_d     = yc_q + YEAR_W'(1);
          mod4_d   = mod4_q + 2'd1;
          mod100_d = (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
          mod400_d = (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
        end else begin
          mc_d    = MON_JAN;
          state_d = S_RM;
        end
      end

      S_RM: begin
        if (acc_q >= mlen_c && mc_q != MON_DEC) begin
          acc_d = acc_q - mlen_c;
          mc_d  = mc_q + MON_W'(1);
        end else begin
          ry_d    = yc_q;
          rm_d    = mc_q;
          rd_d    = DAY_W'(acc_q) + DAY_W'(1);
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        // move the result into the output register once it is free
        if (out_free) begin
          ores_y_d    = ry_q;
          ores_m_d    = rm_q;
          ores_d_d    = rd_q;
          odiff_d     = diff_q;
          ost_d       = st_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    y_q      <= y_d;
    m_q      <= m_d;
    d_q      <= d_d;
    off_q    <= off_d;
    oy_q     <= oy_d;
    om_q     <= om_d;
    od_q     <= od_d;
    acc_q    <= acc_d;
    n1_q     <= n1_d;
    yc_q     <= yc_d;
    mc_q     <= mc_d;
    mod4_q   <= mod4_d;
    mod100_q <= mod100_d;
    mod400_q <= mod400_d;
    ry_q     <= ry_d;
    rm_q     <= rm_d;
    rd_q     <= rd_d;
    diff_q   <= diff_d;
    st_q     <= st_d;
    ores_y_q <= ores_y_d;
    ores_m_q <= ores_m_d;
    ores_d_q <= ores_d_d;
    odiff_q  <= odiff_d;
    ost_q    <= ost_d;
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign result_year_o    = ores_y_q;
  assign result_month_o   = ores_m_q;
  assign result_day_o     = ores_d_q;
  assign day_difference_o = odiff_q;
  assign status_o         = ost_q;

  // Invalid input never leaks partial date or difference values
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_BAD |->
      result_year_o == '0 && result_month_o == '0 && result_day_o == '0 &&
      day_difference_o == '0)
    else $error("invalid-input result carries nonzero fields");

  // An accepted transaction starts the walk or goes straight to hand-off
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_DNY || state_q == S_FIN)
    else $error("accepted transaction did not start the sequencer");

  // Month walk remainder stays inside one year
  a_rm_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RM |-> acc_q < DN_W'(366))
    else $error("year walk left more than a year");

  // Month counter stays within the calendar during month walks
  a_mon_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DNM || state_q == S_RM |-> mc_q >= MON_JAN && mc_q <= MON_DEC)
    else $error("month counter out of range");

  // Hand-off to a free output register completes in the next cycle
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN && !(out_valid_o && out_stall_i) |=>
      out_valid_o && state_q == S_IDLE)
    else $error("result not handed to output register");

endmodule
